### sv/stereo_downmix_fir_decimator_unit_defines.svh
// Assertion helpers for the top-level RTL file; each expects clk and rst_n in scope.
`ifndef STEREO_DOWNMIX_FIR_DECIMATOR_UNIT_DEFINES_SVH
`define STEREO_DOWNMIX_FIR_DECIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SDFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdfd: assertion failed");

// Next-cycle implication, disabled while in reset
`define SDFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdfd: assertion failed");

`endif

### sv/sdfd_pkg.sv
package sdfd_pkg;

    localparam int TAPS_DEF        = 32;
    localparam int DECIMATION_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 18;

    localparam int ROM_LEN  = 32;
    localparam int ROM_FRAC = 17;

    // Lowpass taps, Q1.17
    localparam int LOWPASS_ROM [ROM_LEN] = '{
        -36, 56, 195, 358, 427, 277, -207, -1022,
        -1932, -2551, -2414, -1118, 1515, 5339, 9847, 14308,
        17938, 20085, 20361, 18764, 15580, 11292, 6534, 1952,
        -1861, -4543, -5938, -6092, -5218, -3647, -1755, 0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } state_t;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;   // shift a new mono sample in, clear the accumulator
        logic step;   // issue one tap and rotate the history
        logic round;  // add the rounding offset to the finished sum
    } sdfd_ctrl_t;

    // Coefficient for tap idx rescaled to cb bits, truncated toward zero
    function automatic int coef_at(int unsigned idx, int cb);
        int v;
        int m;
        int sh;
        if (idx >= ROM_LEN)
        begin
            return 0;
        end
        v = LOWPASS_ROM[idx];
        if (cb - 1 >= ROM_FRAC)
        begin
            return v <<< (cb - 1 - ROM_FRAC);
        end
        sh = ROM_FRAC - (cb - 1);
        m = (v < 0) ? -v : v;
        m = m >>> sh;
        return (v < 0) ? -m : m;
    endfunction

endpackage

### sv/sdfd_history.sv
module sdfd_history #(
    parameter int TAPS        = sdfd_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = sdfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdfd_pkg::sdfd_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic signed [SAMPLE_BITS-1:0] tap_sample
);
    import sdfd_pkg::*;

    logic signed [SAMPLE_BITS:0]   mix_sum;
    logic signed [SAMPLE_BITS-1:0] mono;
    logic signed [SAMPLE_BITS-1:0] hist_reg  [TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_next [TAPS];

    // floor((L+R)/2) always fits the sample width
    assign mix_sum = (SAMPLE_BITS+1)'(left_sample) + (SAMPLE_BITS+1)'(right_sample);
    assign mono    = mix_sum[SAMPLE_BITS:1];

    // Entry 0 holds the newest sample; a full rotation restores the order
    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.load)
        begin
            hist_next[0] = mono;
            for (int i = 1; i < TAPS; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                hist_next[i] = hist_reg[i+1];
            end
            hist_next[TAPS-1] = hist_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '{default: '0};
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    assign tap_sample = hist_reg[0];

endmodule

### sv/sdfd_mac.sv
module sdfd_mac #(
    parameter int TAPS        = sdfd_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = sdfd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sdfd_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdfd_pkg::sdfd_ctrl_t          ctrl,
    input  logic [$clog2(TAPS)-1:0]       tap_index,
    input  logic signed [SAMPLE_BITS-1:0] tap_sample,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import sdfd_pkg::*;

    localparam int IDX_W  = $clog2(TAPS);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (COEF_BITS - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [COEF_BITS-1:0] coef;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        prod_vld_reg, prod_vld_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [ACC_W-1:0]     rnd_reg, rnd_next;
    logic signed [ACC_W-1:0]     scaled;

    assign coef = COEF_BITS'(coef_at(int'(tap_index), COEF_BITS));

    always_comb
    begin
        prod_next     = prod_reg;
        prod_vld_next = ctrl.step;
        acc_next      = acc_reg;
        rnd_next      = rnd_reg;
        if (ctrl.step)
        begin
            prod_next = PROD_W'(tap_sample) * PROD_W'(coef);
        end
        if (ctrl.load)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.round)
        begin
            rnd_next = acc_reg + HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rnd_reg  <= rnd_next;
    end

    // Drop the coefficient fraction, then clamp to the sample range
    always_comb
    begin
        scaled = rnd_reg >>> (COEF_BITS - 1);
        if (scaled > SAT_HI)
        begin
            result = SAMPLE_BITS'(SAT_HI);
        end
        else if (scaled < SAT_LO)
        begin
            result = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            result = SAMPLE_BITS'(scaled);
        end
    end

endmodule

### sv/stereo_downmix_fir_decimator_unit.sv
// Stereo downmix, lowpass FIR and decimator. Each accepted frame is mixed to
// mono, shifted into a TAPS-deep history and filtered by one shared multiplier
// that walks the history as it rotates past, one tap per cycle. A frame is
// loaded, multiplied through all TAPS taps and then drains the product
// register; an emitting frame then rounds and hands the word to the output
// register. Every DECIMATION-th frame, counted from reset or from a frame
// with block_start set, yields a rounded, saturated word. The output register
// holds that word while the next frame is taken in; an emitting frame that
// finishes while it is still full waits until the word is taken.
`include "stereo_downmix_fir_decimator_unit_defines.svh"

module stereo_downmix_fir_decimator_unit #(
    parameter int TAPS        = sdfd_pkg::TAPS_DEF,
    parameter int DECIMATION  = sdfd_pkg::DECIMATION_DEF,
    parameter int SAMPLE_BITS = sdfd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sdfd_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          block_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] filtered_sample
);
    import sdfd_pkg::*;

    localparam int IDX_W = $clog2(TAPS);
    localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              tap_reg, tap_next;
    logic [PH_W-1:0]               phase_reg, phase_next;
    logic                          emit_reg, emit_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;
    logic [PH_W-1:0]               phase_eff;
    logic [PH_W:0]                 phase_cnt;
    logic                          phase_wrap;
    logic                          accept;
    logic                          out_load;
    sdfd_ctrl_t                    ctrl;
    logic signed [SAMPLE_BITS-1:0] tap_sample;
    logic signed [SAMPLE_BITS-1:0] mac_result;

    sdfd_history #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_history (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .tap_sample   (tap_sample)
    );

    sdfd_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .tap_index  (tap_reg),
        .tap_sample (tap_sample),
        .result     (mac_result)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Block start restarts the group before this frame is counted
    assign phase_eff  = block_start ? '0 : phase_reg;
    assign phase_cnt  = (PH_W+1)'(phase_eff) + (PH_W+1)'(1);
    assign phase_wrap = (phase_cnt >= (PH_W+1)'(DECIMATION));

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        phase_next     = phase_reg;
        emit_next      = emit_reg;
        out_load       = 1'b0;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    tap_next   = '0;
                    emit_next  = phase_wrap;
                    phase_next = phase_wrap ? '0 : phase_cnt[PH_W-1:0];
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                ctrl.step = 1'b1;
                tap_next  = tap_reg + IDX_W'(1);
                if (tap_reg == IDX_W'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = emit_reg ? ST_ROUND : ST_IDLE;
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the previous word has left the output register
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_data_next  = mac_result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            phase_reg     <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            phase_reg     <= phase_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;

    `SDFD_ASSERT_NEXT(a_accept_starts_mac, accept, state_reg == ST_MAC && tap_reg == '0)
    `SDFD_ASSERT_NEXT(a_last_tap_drains, state_reg == ST_MAC && tap_reg == IDX_W'(TAPS - 1),
                      state_reg == ST_DRAIN)
    `SDFD_ASSERT_NEXT(a_quiet_frame_idles, state_reg == ST_DRAIN && !emit_reg,
                      state_reg == ST_IDLE && !$rose(out_valid_reg))
    `SDFD_ASSERT_SAME(a_word_from_out_state, $rose(out_valid_reg), $past(state_reg == ST_OUT))

endmodule
